// File: rtl/cfi_pkg.sv
package cfi_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int ACTION_W   = 2;
  localparam int CIDX_W     = 7;
  localparam int FRAC_SHIFT = 17;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int TAPS_W     = 8;
  localparam int SPS_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPS       = 2'd1;

  localparam logic [TAPS_W-1:0] TAP_COUNT_RST = 8'd33;
  localparam logic [SPS_W-1:0]  SPS_RST       = 4'd4;

  // Item kinds
  localparam logic [ACTION_W-1:0] ACT_FILTER   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_UPSAMPLE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD     = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd3;

  // Default sizes
  localparam int DEF_MAX_TAPS = 128;
  localparam int DEF_MAX_SPS  = 8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] i;
    logic signed [SAMPLE_W-1:0] q;
  } iq_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic rotate;
    logic wrap;
  } cfi_cell_ctl_t;

endpackage

// File: rtl/cfi_if.sv
interface cfi_in_if
  import cfi_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [CIDX_W-1:0]          coeff_index;
  logic signed [COEF_W-1:0]   coeff_value;

  modport source (
    output valid, action, sample_i, sample_q, coeff_index, coeff_value,
    input  ready
  );
  modport sink (
    input  valid, action, sample_i, sample_q, coeff_index, coeff_value,
    output ready
  );
endinterface

interface cfi_out_if
  import cfi_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered_i;
  logic signed [SAMPLE_W-1:0] filtered_q;
  logic                       last;

  modport source (
    output valid, filtered_i, filtered_q, last,
    input  ready
  );
  modport sink (
    input  valid, filtered_i, filtered_q, last,
    output ready
  );
endinterface

// File: rtl/cfi_cell.sv
module cfi_cell
  import cfi_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfi_cell_ctl_t ctl,
  input  iq_t           nbr,
  input  iq_t           head,
  input  iq_t           wdata,
  output iq_t           value
);

  // One delay line entry: clear, take a new sample, or rotate toward cell 0
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      value <= '0;
    end else if (ctl.load) begin
      value <= wdata;
    end else if (ctl.rotate) begin
      value <= ctl.wrap ? head : nbr;
    end
  end

endmodule

// File: rtl/cfi_mac.sv
module cfi_mac
  import cfi_pkg::*;
#(
  parameter int MAX_TAPS = DEF_MAX_TAPS
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     issue,
  input  iq_t                      samp,
  input  logic signed [COEF_W-1:0] coef,
  output logic                     busy,
  output iq_t                      result
);

  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
  localparam int RND_W  = ACC_W + 1 - FRAC_SHIFT;
  localparam logic [ACC_W:0] RND_HALF = (ACC_W + 1)'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

  logic                     v1;
  logic                     v2;
  iq_t                      s1;
  logic signed [PROD_W-1:0] p_i;
  logic signed [PROD_W-1:0] p_q;
  logic signed [ACC_W-1:0]  acc_i;
  logic signed [ACC_W-1:0]  acc_q;

  // Round half up, drop the fraction bits, saturate to the sample width
  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic [ACC_W:0]          sum;
    logic signed [RND_W-1:0] sh;
    sum = {a[ACC_W-1], a} + RND_HALF;
    sh  = sum[ACC_W:FRAC_SHIFT];
    if (sh[RND_W-1:SAMPLE_W-1] == '0 || sh[RND_W-1:SAMPLE_W-1] == '1) begin
      return sh[SAMPLE_W-1:0];
    end else if (sh[RND_W-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  // Align sample with registered coefficient, multiply, accumulate
  always_ff @(posedge clk) begin
    s1  <= samp;
    p_i <= s1.i * coef;
    p_q <= s1.q * coef;
    if (clear) begin
      acc_i <= '0;
      acc_q <= '0;
    end else if (v2) begin
      acc_i <= acc_i + ACC_W'(p_i);
      acc_q <= acc_q + ACC_W'(p_q);
    end
  end

  assign busy   = v1 | v2;
  assign result = '{i: round_sat(acc_i), q: round_sat(acc_q)};

endmodule

// File: rtl/complex_fir_interpolator.sv
// Complex I/Q FIR filter and interpolator. Each accepted item is one of four kinds: a filter
// sample (one result), an upsample symbol (samples_per_symbol results, the symbol first and
// then zero-stuffed samples, with last set on the final one), a coefficient load or a delay
// line clear (no result). The delay line is a row of MAX_TAPS cells; for each result the
// first tap_count cells rotate once around their ring while cell 0 feeds a single complex
// multiply-accumulate and a counter walks the coefficient memory in step. Each result takes
// one write, the rotate/MAC pass, a drain of the multiplier pipeline and a step that
// rounds and registers the result; a symbol item repeats this for each of its results. The
// output register lets a new item enter while the last result of the previous one waits.
// Coefficients are undefined until loaded.
// The registers take a write in any cycle; write them only while no item is in flight.
module complex_fir_interpolator
  import cfi_pkg::*;
#(
  parameter int MAX_TAPS = DEF_MAX_TAPS,
  parameter int MAX_SPS  = DEF_MAX_SPS
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cfi_in_if.sink                samples,
  cfi_out_if.source             results
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam int NW = $clog2(MAX_TAPS + 1);
  localparam int SW = $clog2(MAX_SPS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]             state;
  logic [TAPS_W-1:0]      tap_count;
  logic [SPS_W-1:0]       samples_per_symbol;
  logic [AW-1:0]          wp;
  logic [SW-1:0]          remaining;
  logic [AW-1:0]          caddr;
  logic [NW-1:0]          rcnt;
  iq_t                    xin;
  logic signed [COEF_W-1:0] coef_mem [MAX_TAPS];
  logic signed [COEF_W-1:0] coef_q;

  iq_t                    out_iq;
  logic                   out_valid;
  logic                   out_last;

  logic [NW-1:0]          nt_eff;
  logic [NW-1:0]          nt_last;
  logic [SW-1:0]          sps_eff;
  logic [AW-1:0]          wp_eff;
  logic [NW-1:0]          wp_plus;
  logic [AW-1:0]          wp_next;
  logic                   in_accept;
  logic                   line_clear;
  logic                   coef_we;
  logic                   out_free;
  logic                   out_load;

  iq_t                    cell_val [MAX_TAPS];
  logic                   mac_busy;
  iq_t                    mac_res;

  // Effective tap count and outputs per symbol, clamped to the legal range
  always_comb begin
    if (tap_count == '0) begin
      nt_eff = NW'(1);
    end else if (int'(tap_count) > MAX_TAPS) begin
      nt_eff = NW'(MAX_TAPS);
    end else begin
      nt_eff = NW'(tap_count);
    end
    if (samples_per_symbol == '0) begin
      sps_eff = SW'(1);
    end else if (int'(samples_per_symbol) > MAX_SPS) begin
      sps_eff = SW'(MAX_SPS);
    end else begin
      sps_eff = SW'(samples_per_symbol);
    end
  end

  assign nt_last = nt_eff - NW'(1);

  // A write pointer left beyond a shrunken ring restarts at zero
  assign wp_eff  = (NW'(wp) >= nt_eff) ? '0 : wp;
  assign wp_plus = NW'(wp_eff) + NW'(1);
  assign wp_next = (wp_plus == nt_eff) ? '0 : AW'(wp_plus);

  assign samples.ready = (state == ST_IDLE);
  assign in_accept     = samples.valid && samples.ready;
  assign line_clear    = in_accept && (samples.action == ACT_CLEAR);
  assign coef_we       = in_accept && (samples.action == ACT_LOAD) &&
                         (int'(samples.coeff_index) < MAX_TAPS);

  assign out_free = !out_valid || results.ready;
  assign out_load = (state == ST_OUT) && out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count          <= TAP_COUNT_RST;
      samples_per_symbol <= SPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAP_COUNT: tap_count          <= cfg_data[TAPS_W-1:0];
        REG_SPS:       samples_per_symbol <= cfg_data[SPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: write one sample, rotate the ring through the MAC, drain, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      remaining <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            unique case (samples.action)
              ACT_FILTER: begin
                remaining <= SW'(1);
                state     <= ST_WRITE;
              end
              ACT_UPSAMPLE: begin
                remaining <= sps_eff;
                state     <= ST_WRITE;
              end
              ACT_CLEAR: wp <= '0;
              default: ;
            endcase
          end
        end
        ST_WRITE: begin
          wp    <= wp_next;
          state <= ST_MAC;
        end
        ST_MAC: begin
          if (rcnt == nt_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!mac_busy) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            remaining <= remaining - SW'(1);
            state     <= (remaining == SW'(1)) ? ST_IDLE : ST_WRITE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the sample for the write; zero-stuffed samples follow the first result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      xin <= '{i: samples.sample_i, q: samples.sample_q};
    end else if (out_load) begin
      xin <= '0;
    end
    // The coefficient counter starts at the write position and walks down the ring
    if (state == ST_WRITE) begin
      caddr <= wp_eff;
      rcnt  <= '0;
    end else if (state == ST_MAC) begin
      caddr <= (caddr == '0) ? AW'(nt_last) : caddr - AW'(1);
      rcnt  <= rcnt + NW'(1);
    end
  end

  // Coefficient memory: one write port for loads, one registered read port for the MAC
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[AW'(samples.coeff_index)] <= samples.coeff_value;
    end
  end

  always_ff @(posedge clk) begin
    coef_q <= coef_mem[caddr];
  end

  // Delay line: cell j holds ring position j; cells at or beyond the tap count hold still
  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    cfi_cell_ctl_t ctl;
    iq_t           nbr;

    assign ctl = '{
      clear:  line_clear,
      load:   (state == ST_WRITE) && (wp_eff == AW'(j)),
      rotate: (state == ST_MAC) && (NW'(j) < nt_eff),
      wrap:   (NW'(j) == nt_last)
    };

    if (j == MAX_TAPS - 1) begin : g_end
      assign nbr = cell_val[0];
    end else begin : g_mid
      assign nbr = cell_val[j + 1];
    end

    cfi_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .nbr   (nbr),
      .head  (cell_val[0]),
      .wdata (xin),
      .value (cell_val[j])
    );
  end

  cfi_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (state == ST_WRITE),
    .issue  (state == ST_MAC),
    .samp   (cell_val[0]),
    .coef   (coef_q),
    .busy   (mac_busy),
    .result (mac_res)
  );

  // Output register: hold a result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_iq   <= mac_res;
      out_last <= (remaining == SW'(1));
    end
  end

  assign results.valid      = out_valid;
  assign results.filtered_i = out_iq.i;
  assign results.filtered_q = out_iq.q;
  assign results.last       = out_last;

endmodule

// File: rtl/cfi_checker.sv
module cfi_checker
  import cfi_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [ACTION_W-1:0]        in_action,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_last,
  input logic signed [SAMPLE_W-1:0] out_i,
  input logic signed [SAMPLE_W-1:0] out_q
);

  // A waiting result that is not the last of its item means the item is still in work
  a_mid_item_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> !in_ready)
    else $error("input ready while an item still owes results");

  a_sample_starts_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_action == ACT_FILTER || in_action == ACT_UPSAMPLE))
    |=> !in_ready)
    else $error("input ready right after a sample or symbol item");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid &&
     (in_action == ACT_LOAD || in_action == ACT_CLEAR)) |=> !out_valid)
    else $error("result produced by a load or clear item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
    (out_valid && $stable(out_i) && $stable(out_q) && $stable(out_last)))
    else $error("stalled result changed or dropped");

endmodule

bind complex_fir_interpolator cfi_checker u_cfi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .in_action (samples.action),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_last  (results.last),
  .out_i     (results.filtered_i),
  .out_q     (results.filtered_q)
);
